@@ rtl/histogram_matching_lut_unit_macros.svh @@
// Assertion macros for the histogram matching LUT unit.
`ifndef HISTOGRAM_MATCHING_LUT_UNIT_MACROS_SVH
`define HISTOGRAM_MATCHING_LUT_UNIT_MACROS_SVH
`ifndef SYNTH
`define HML_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) else $error(msg);
`define HML_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);
`else
`define HML_ASSERT_IMP(lbl, pre, post, msg)
`define HML_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/hml_pkg.sv @@
// Shared types and constants of the histogram matching LUT unit.
package hml_pkg;

    localparam logic [7:0] TOP = 8'd255;

    typedef enum logic [2:0] {
        OP_COUNT_IN  = 3'd0,
        OP_COUNT_REF = 3'd1,
        OP_BUILD     = 3'd2,
        OP_MAP       = 3'd3,
        OP_CLEAR     = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_IN,
        ST_CNT_REF,
        ST_MAP,
        ST_B_RD,
        ST_B_ACC,
        ST_B_GO,
        ST_B_DIV,
        ST_B_UPD,
        ST_F_RD,
        ST_F_WR,
        ST_M_RD,
        ST_M_ACC,
        ST_M_GO,
        ST_M_DIV,
        ST_M_INV,
        ST_M_WR
    } state_t;

    typedef struct packed {
        logic clr_cnt;
        logic idx_zero;
        logic idx_inc;
        logic s_inc;
        logic lat_lvl;
        logic rd_in_lvl;
        logic rd_ref_lvl;
        logic inc_in;
        logic inc_ref;
        logic clr_hist;
        logic clr_map;
        logic rd_ref_idx;
        logic rd_in_idx;
        logic cum_zero;
        logic cum_add;
        logic div_start;
        logic sel_in;
        logic valid_clr;
        logic inv_upd;
        logic fill_rd;
        logic fill_wr;
        logic inv_rd_q;
        logic map_rd;
        logic map_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic s_last;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/hml_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/hml_div.sv @@
// Restoring divider: floor(255 * cum / den), one quotient bit per cycle.
module hml_div #(
    parameter int CW = 21
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] cum,
    input  logic [CW-1:0] den,
    output logic [7:0]    q,
    output logic          busy
);
    localparam int DW = CW + 8;

    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] den_reg, den_next;
    logic [7:0]    q_reg, q_next;
    logic [2:0]    k_reg, k_next;
    logic          busy_reg, busy_next;
    logic [DW-1:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        k_reg   <= k_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        shifted   = DW'(den_reg) << k_reg;
        if (start) begin
            rem_next  = {cum, 8'b0} - DW'(cum);
            den_next  = den;
            q_next    = '0;
            k_next    = 3'd7;
            busy_next = (den != '0);
        end else if (busy_reg) begin
            if (rem_reg >= shifted) begin
                rem_next      = rem_reg - shifted;
                q_next[k_reg] = 1'b1;
            end
            if (k_reg == 3'd0) begin
                busy_next = 1'b0;
            end else begin
                k_next = k_reg - 3'd1;
            end
        end
    end

    assign q    = q_reg;
    assign busy = busy_reg;
endmodule

@@ rtl/hml_datapath.sv @@
// Datapath: histograms, counts, divider, inverse table and map table.
module hml_datapath import hml_pkg::*; #(
    parameter int LEVELS     = 256,
    parameter int MAX_PIXELS = 1048576
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] pixel,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_mapped_pixel
);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int EW = ((LW > 8) ? LW : 8) + 1;

    logic [LW-1:0]  idx_reg, idx_next, lvl_reg, lvl;
    logic [7:0]     s_reg, s_next, prev_reg, prev_next;
    logic [CW-1:0]  in_cnt_reg, in_cnt_next, ref_cnt_reg, ref_cnt_next;
    logic [CW-1:0]  cum_reg, cum_next;
    logic [255:0]   valid_reg, valid_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_data_reg, m_data_next;
    logic [EW-1:0]  pix_ext, idx_ext;
    logic [CW-1:0]  in_rdata, ref_rdata;
    logic [7:0]     inv_rdata, map_rdata, q, zsat, fill_val;
    logic           div_busy, in_ok, ref_ok;

    assign pix_ext = EW'(pixel);
    assign lvl     = (pix_ext >= EW'(LEVELS)) ? LW'(LEVELS - 1) : pix_ext[LW-1:0];
    assign idx_ext = EW'(idx_reg);
    assign zsat    = (idx_ext > EW'(TOP)) ? TOP : idx_ext[7:0];
    assign in_ok   = in_cnt_reg < CW'(MAX_PIXELS);
    assign ref_ok  = ref_cnt_reg < CW'(MAX_PIXELS);

    always_comb begin
        if (valid_reg[s_reg]) begin
            fill_val = inv_rdata;
        end else if (s_reg == 8'd0) begin
            fill_val = 8'd0;
        end else if (prev_reg == TOP) begin
            fill_val = TOP;
        end else begin
            fill_val = prev_reg + 8'd1;
        end
    end

    hml_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_in_hist (
        .aclk  (aclk),
        .we    (cmd.clr_hist | (cmd.inc_in & in_ok)),
        .waddr (cmd.clr_hist ? idx_reg : lvl_reg),
        .wdata (cmd.clr_hist ? '0 : in_rdata + CW'(1)),
        .re    (cmd.rd_in_lvl | cmd.rd_in_idx),
        .raddr (cmd.rd_in_lvl ? lvl : idx_reg),
        .rdata (in_rdata)
    );

    hml_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_ref_hist (
        .aclk  (aclk),
        .we    (cmd.clr_hist | (cmd.inc_ref & ref_ok)),
        .waddr (cmd.clr_hist ? idx_reg : lvl_reg),
        .wdata (cmd.clr_hist ? '0 : ref_rdata + CW'(1)),
        .re    (cmd.rd_ref_lvl | cmd.rd_ref_idx),
        .raddr (cmd.rd_ref_lvl ? lvl : idx_reg),
        .rdata (ref_rdata)
    );

    hml_ram #(.WIDTH(8), .DEPTH(256)) u_inv (
        .aclk  (aclk),
        .we    ((cmd.inv_upd & ~valid_reg[q]) | cmd.fill_wr),
        .waddr (cmd.fill_wr ? s_reg : q),
        .wdata (cmd.fill_wr ? fill_val : zsat),
        .re    (cmd.fill_rd | cmd.inv_rd_q),
        .raddr (cmd.fill_rd ? s_reg : q),
        .rdata (inv_rdata)
    );

    hml_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_map (
        .aclk  (aclk),
        .we    (cmd.clr_map | cmd.map_wr),
        .waddr (idx_reg),
        .wdata (cmd.map_wr ? inv_rdata : 8'd0),
        .re    (cmd.map_rd),
        .raddr (lvl),
        .rdata (map_rdata)
    );

    hml_div #(.CW(CW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .cum     (cum_reg),
        .den     (cmd.sel_in ? in_cnt_reg : ref_cnt_reg),
        .q       (q),
        .busy    (div_busy)
    );

    always_comb begin
        idx_next     = idx_reg;
        s_next       = s_reg;
        in_cnt_next  = in_cnt_reg;
        ref_cnt_next = ref_cnt_reg;
        cum_next     = cum_reg;
        valid_next   = valid_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.idx_zero) begin
            idx_next = '0;
            s_next   = '0;
        end else if (cmd.idx_inc) begin
            idx_next = sts.idx_last ? '0 : idx_reg + LW'(1);
        end
        if (cmd.s_inc) begin
            s_next = s_reg + 8'd1;
        end
        if (cmd.clr_cnt) begin
            in_cnt_next  = '0;
            ref_cnt_next = '0;
        end
        if (cmd.inc_in && in_ok) begin
            in_cnt_next = in_cnt_reg + CW'(1);
        end
        if (cmd.inc_ref && ref_ok) begin
            ref_cnt_next = ref_cnt_reg + CW'(1);
        end
        if (cmd.cum_zero) begin
            cum_next = '0;
        end else if (cmd.cum_add) begin
            cum_next = cum_reg + (cmd.sel_in ? in_rdata : ref_rdata);
        end
        if (cmd.valid_clr) begin
            valid_next = '0;
        end else if (cmd.inv_upd) begin
            valid_next[q] = 1'b1;
        end
        if (cmd.fill_wr) begin
            prev_next = fill_val;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = map_rdata;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            s_reg       <= '0;
            in_cnt_reg  <= '0;
            ref_cnt_reg <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            s_reg       <= s_next;
            in_cnt_reg  <= in_cnt_next;
            ref_cnt_reg <= ref_cnt_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        if (cmd.lat_lvl) begin
            lvl_reg <= lvl;
        end
        cum_reg    <= cum_next;
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
    end

    assign sts.idx_last    = (idx_reg == LW'(LEVELS - 1));
    assign sts.s_last      = (s_reg == TOP);
    assign sts.div_busy    = div_busy;
    assign sts.out_free    = ~m_valid_reg | m_ready;
    assign m_valid         = m_valid_reg;
    assign m_mapped_pixel  = m_data_reg;
endmodule

@@ rtl/hml_ctrl.sv @@
// Controller: sequences counting, clearing, map building and lookups.
module hml_ctrl import hml_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_op,
    output logic       s_ready,
    output cmd_t       cmd,
    input  sts_t       sts
);
    state_t state_reg, state_next;
    logic   clr_map_reg, clr_map_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_map_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            clr_map_reg <= clr_map_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_map_next = clr_map_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_hist = 1'b1;
                cmd.clr_map  = clr_map_reg;
                cmd.idx_inc  = 1'b1;
                if (sts.idx_last) begin
                    state_next   = ST_IDLE;
                    clr_map_next = 1'b0;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (op_t'(s_op))
                        OP_COUNT_IN: begin
                            cmd.rd_in_lvl = 1'b1;
                            cmd.lat_lvl   = 1'b1;
                            state_next    = ST_CNT_IN;
                        end
                        OP_COUNT_REF: begin
                            cmd.rd_ref_lvl = 1'b1;
                            cmd.lat_lvl    = 1'b1;
                            state_next     = ST_CNT_REF;
                        end
                        OP_BUILD: begin
                            cmd.idx_zero  = 1'b1;
                            cmd.cum_zero  = 1'b1;
                            cmd.valid_clr = 1'b1;
                            state_next    = ST_B_RD;
                        end
                        OP_MAP: begin
                            cmd.map_rd = 1'b1;
                            state_next = ST_MAP;
                        end
                        OP_CLEAR: begin
                            cmd.clr_cnt  = 1'b1;
                            cmd.idx_zero = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CNT_IN: begin
                cmd.inc_in = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CNT_REF: begin
                cmd.inc_ref = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_MAP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_B_RD: begin
                cmd.rd_ref_idx = 1'b1;
                state_next     = ST_B_ACC;
            end
            ST_B_ACC: begin
                cmd.cum_add = 1'b1;
                state_next  = ST_B_GO;
            end
            ST_B_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_B_DIV;
            end
            ST_B_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_B_UPD;
                end
            end
            ST_B_UPD: begin
                cmd.inv_upd = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = sts.idx_last ? ST_F_RD : ST_B_RD;
            end
            ST_F_RD: begin
                cmd.fill_rd = 1'b1;
                state_next  = ST_F_WR;
            end
            ST_F_WR: begin
                cmd.fill_wr = 1'b1;
                cmd.s_inc   = 1'b1;
                if (sts.s_last) begin
                    cmd.idx_zero = 1'b1;
                    cmd.cum_zero = 1'b1;
                    state_next   = ST_M_RD;
                end else begin
                    state_next = ST_F_RD;
                end
            end
            ST_M_RD: begin
                cmd.rd_in_idx = 1'b1;
                state_next    = ST_M_ACC;
            end
            ST_M_ACC: begin
                cmd.cum_add = 1'b1;
                cmd.sel_in  = 1'b1;
                state_next  = ST_M_GO;
            end
            ST_M_GO: begin
                cmd.div_start = 1'b1;
                cmd.sel_in    = 1'b1;
                state_next    = ST_M_DIV;
            end
            ST_M_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_M_INV;
                end
            end
            ST_M_INV: begin
                cmd.inv_rd_q = 1'b1;
                state_next   = ST_M_WR;
            end
            ST_M_WR: begin
                cmd.map_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = sts.idx_last ? ST_IDLE : ST_M_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/histogram_matching_lut_unit.sv @@
// Histogram matching LUT unit: top level.
// Input channel s_valid/s_ready carries one word of s_op and s_pixel.
// s_op selects: count an input pixel, count a reference pixel, build the map,
// map a pixel, or clear both histograms and counts.
// Result channel m_valid/m_ready carries m_mapped_pixel, one word per map op.
// Counting does a histogram read-modify-write in one RAM for each word.
// A map op reads the map table into the output register; a finished word waits in
// the output register while further non-map words are accepted, and a later
// map op waits only for that register to free.
// A build walks both histograms and the inverse table, with two restoring divisions per level.
// A clear op empties the histograms one row per cycle and zeroes the counts.
// After reset a clearing pass empties the histograms and the map table;
// s_ready stays low until it ends. A map before any build gives 0.
// While m_ready is low a pending word holds and a map op stalls behind it.
`include "histogram_matching_lut_unit_macros.svh"
module histogram_matching_lut_unit import hml_pkg::*; #(
    parameter int LEVELS     = 256,
    parameter int MAX_PIXELS = 1048576
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_pixel,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_mapped_pixel
);
    cmd_t cmd;
    sts_t sts;

    hml_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    hml_datapath #(.LEVELS(LEVELS), .MAX_PIXELS(MAX_PIXELS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pixel          (s_pixel),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mapped_pixel (m_mapped_pixel)
    );

    `HML_ASSERT_IMP(a_idle_div, s_ready, !sts.div_busy, "divider busy while idle")
    `HML_ASSERT_IMP(a_upd_div, cmd.inv_upd, !sts.div_busy, "inverse update before quotient")
    `HML_ASSERT_NXT(a_no_spurious, s_valid && s_ready && s_op != OP_MAP, !$rose(m_valid), "result without map op")
endmodule

@@ tb/tb_histogram_matching_lut_unit.sv @@
// Testbench for the histogram matching LUT unit: directed table, random traffic, scoreboard.
module tb_histogram_matching_lut_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hml_pkg::*;

    localparam int LEVELS     = 256;
    localparam int MAX_PIXELS = 1048576;
    localparam int N_RANDOM   = 1050;
    localparam logic [2:0] OP_SPARE     = 3'd7;
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_op = '0;
    logic [7:0] s_pixel = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_mapped_pixel;

    histogram_matching_lut_unit #(.LEVELS(LEVELS), .MAX_PIXELS(MAX_PIXELS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_mapped_pixel(m_mapped_pixel)
    );

    always #4 aclk = ~aclk;

    typedef struct {
        logic [2:0] op;
        logic [7:0] pixel;
        bit         fixed;
        logic [7:0] mapped;
    } stim_row_t;

    int unsigned in_hist [LEVELS];
    int unsigned ref_hist [LEVELS];
    int unsigned in_cnt, ref_cnt;
    logic [7:0]  lut [LEVELS];
    logic [7:0]  pending_mapped [$];
    bit          fixed_mask [$];
    logic [7:0]  fixed_value [$];
    int          errors = 0;
    bit          long_hold = 1'b0;

    function automatic logic [7:0] scale_cum(longint unsigned cum, longint unsigned n);
        longint unsigned v;
        if (n == 0) return 8'd0;
        v = (255 * cum) / n;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    task automatic rebuild_lut();
        logic [7:0]      inv [256];
        bit              set [256];
        longint unsigned cum;
        logic [7:0]      lvl;
        cum = 0;
        for (int s = 0; s < 256; s++) set[s] = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            cum += ref_hist[i];
            lvl = scale_cum(cum, ref_cnt);
            if (!set[lvl]) begin
                inv[lvl] = (i > 255) ? 8'd255 : i[7:0];
                set[lvl] = 1'b1;
            end
        end
        if (!set[0]) inv[0] = 8'd0;
        for (int s = 1; s < 256; s++)
            if (!set[s]) inv[s] = (inv[s-1] == 8'd255) ? 8'd255 : inv[s-1] + 8'd1;
        cum = 0;
        for (int i = 0; i < LEVELS; i++) begin
            cum += in_hist[i];
            lut[i] = inv[scale_cum(cum, in_cnt)];
        end
    endtask

    task automatic predict_word(logic [2:0] op, logic [7:0] pixel, bit fixed, logic [7:0] val);
        int lv;
        lv = (pixel >= LEVELS) ? LEVELS - 1 : pixel;
        case (op)
            OP_COUNT_IN:  if (in_cnt < MAX_PIXELS) begin in_hist[lv]++; in_cnt++; end
            OP_COUNT_REF: if (ref_cnt < MAX_PIXELS) begin ref_hist[lv]++; ref_cnt++; end
            OP_BUILD:     rebuild_lut();
            OP_MAP: begin
                pending_mapped.push_back(lut[lv]);
                fixed_mask.push_back(fixed);
                fixed_value.push_back(val);
            end
            OP_CLEAR: begin
                for (int i = 0; i < LEVELS; i++) begin in_hist[i] = 0; ref_hist[i] = 0; end
                in_cnt = 0;
                ref_cnt = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(logic [2:0] op, logic [7:0] pixel, bit fixed = 0,
                             logic [7:0] val = 0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_pixel <= pixel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(op, pixel, fixed, val);
    endtask

    task automatic wait_drain();
        while (pending_mapped.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    stim_row_t directed [$] = '{
        '{OP_MAP, 8'd0, 1, 8'd0}, '{OP_MAP, 8'd255, 1, 8'd0}, '{OP_BUILD, 8'd0, 1, 8'd0},
        '{OP_MAP, 8'd128, 1, 8'd0}, '{OP_COUNT_IN, 8'd0, 0, 0}, '{OP_COUNT_IN, 8'd255, 0, 0},
        '{OP_COUNT_REF, 8'd255, 0, 0}, '{OP_BUILD, 8'hAA, 0, 0}, '{OP_MAP, 8'd0, 0, 0},
        '{OP_MAP, 8'd255, 0, 0}, '{OP_COUNT_REF, 8'd0, 0, 0}, '{OP_COUNT_REF, 8'd17, 0, 0},
        '{OP_BUILD, 8'd0, 0, 0}, '{OP_MAP, 8'd0, 0, 0}, '{OP_MAP, 8'h55, 0, 0},
        '{OP_SPARE, 8'hFF, 0, 0}, '{OP_SPARE_LO, 8'd1, 0, 0}, '{OP_SPARE_MID, 8'd2, 0, 0},
        '{OP_CLEAR, 8'hFF, 0, 0}, '{OP_COUNT_IN, 8'd7, 0, 0}, '{OP_BUILD, 8'd0, 0, 0},
        '{OP_MAP, 8'd0, 0, 0}, '{OP_MAP, 8'd7, 0, 0}, '{OP_MAP, 8'd200, 0, 0}
    };

    initial begin
        int centre, spread, n_in, n_ref;
        for (int i = 0; i < LEVELS; i++) begin
            in_hist[i] = 0; ref_hist[i] = 0; lut[i] = 8'd0;
        end
        in_cnt = 0;
        ref_cnt = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[k])
            send_word(directed[k].op, directed[k].pixel, directed[k].fixed, directed[k].mapped);
        for (int n = 0; n < N_RANDOM; ) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                n++;
            end else begin
                if ($urandom_range(0, 2) != 0) begin send_word(OP_CLEAR, 8'($urandom)); n++; end
                centre = $urandom_range(0, 255);
                spread = $urandom_range(0, 255);
                n_in  = $urandom_range(0, 12);
                n_ref = $urandom_range(0, 12);
                for (int j = 0; j < n_in; j++) begin
                    send_word(OP_COUNT_IN, ($urandom_range(0, 3) == 0)
                              ? 8'($urandom_range(0, 255))
                              : 8'(centre + $urandom_range(0, spread)));
                    n++;
                end
                for (int j = 0; j < n_ref; j++) begin
                    send_word(OP_COUNT_REF, 8'($urandom_range(0, 255)));
                    n++;
                end
                send_word(OP_BUILD, 8'($urandom));
                n++;
                if (n > N_RANDOM / 2 && !long_hold) long_hold = 1'b1;
                for (int j = $urandom_range(3, 10); j > 0; j--) begin
                    send_word(OP_MAP, 8'($urandom_range(0, 255)));
                    n++;
                end
            end
        end
        s_valid <= 1'b0;
        wait_drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int wait_cycles;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (1) begin
            if (long_hold && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_mapped.size() == 0) begin
                $error("mapped_pixel: unexpected word, actual %0d", m_mapped_pixel);
                errors++;
            end else begin
                if (m_mapped_pixel !== pending_mapped[0]) begin
                    $error("mapped_pixel: expected %0d, actual %0d",
                           pending_mapped[0], m_mapped_pixel);
                    errors++;
                end
                if (fixed_mask[0] && m_mapped_pixel !== fixed_value[0]) begin
                    $error("mapped_pixel: expected %0d, actual %0d",
                           fixed_value[0], m_mapped_pixel);
                    errors++;
                end
                void'(pending_mapped.pop_front());
                void'(fixed_mask.pop_front());
                void'(fixed_value.pop_front());
            end
        end
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hml_pkg.sv
rtl/hml_ram.sv
rtl/hml_div.sv
rtl/hml_datapath.sv
rtl/hml_ctrl.sv
rtl/histogram_matching_lut_unit.sv
tb/tb_histogram_matching_lut_unit.sv
